FILE: rtl/core/lbf_pkg.sv
`timescale 1ns / 1ps
// lbf_pkg: shared types, codes and sizing for the led blink/fade pwm driver
// no dependencies; used by every file under rtl/core except lbf_stream_if

package lbf_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 8;
    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 2;
    localparam int PERIOD_W = 16;
    localparam int NUM_LEDS = 3;
    localparam int NUM_PAT  = 4;

    // default pattern periods in ms
    localparam int unsigned FAST_BLINK_PERIOD_DEF = 250;
    localparam int unsigned BLINK_PERIOD_DEF      = 1000;
    localparam int unsigned FAST_FADE_PERIOD_DEF  = 1000;
    localparam int unsigned FADE_PERIOD_DEF       = 3000;

    // time reduction: restoring steps per stage
    localparam int MOD_BITS   = 4;
    localparam int MOD_STAGES = TIME_W / MOD_BITS;
    // fade quotient: 9 bits, three per stage
    localparam int Q_W        = 9;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = Q_W / DIV_BITS;
    localparam int POST_STAGES = 1 + DIV_STAGES;
    localparam int PIPE_DEPTH  = MOD_STAGES + POST_STAGES;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;
    localparam logic [LEVEL_W:0]   LEVEL_NONE = '1;

    // transaction codes
    localparam logic ACT_UPDATE   = 1'b0;
    localparam logic ACT_SET_MODE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIXED,
        MODE_FAST_BLINK,
        MODE_BLINK,
        MODE_FAST_FADE,
        MODE_FADE
    } mode_t;

    // pattern slots in the level vector
    localparam int PAT_FAST_BLINK = 0;
    localparam int PAT_BLINK      = 1;
    localparam int PAT_FAST_FADE  = 2;
    localparam int PAT_FADE       = 3;

    typedef logic [NUM_PAT-1:0][LEVEL_W-1:0] level_vec_t;

    typedef struct packed {
        logic               action;
        logic [TIME_W-1:0]  time_ms;
        logic               alarm_en;
        logic               battery_en;
        logic               wifi_en;
        logic [INDEX_W-1:0] led_select;
        logic [MODE_W-1:0]  mode_code;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] led_index;
        logic [LEVEL_W-1:0] pwm_level;
        logic               last;
    } out_item_t;

    // command to one led lane
    typedef struct packed {
        logic              is_set;
        logic              set_hit;
        logic [MODE_W-1:0] mode_code;
        logic              lit;
    } lane_cmd_t;

    // what one lane found
    typedef struct packed {
        logic               changed;
        logic [LEVEL_W-1:0] level;
    } lane_res_t;

endpackage

FILE: rtl/core/lbf_stream_if.sv
`timescale 1ns / 1ps
// lbf_stream_if: valid/ready channel carrying one payload per transaction
// no dependencies; payload type set at instantiation

interface lbf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/lbf_period_unit.sv
`timescale 1ns / 1ps
// lbf_period_unit: pipelined time mod period, then blink or triangle fade level
// depends on lbf_pkg

module lbf_period_unit #(
    parameter int unsigned PERIOD  = lbf_pkg::FADE_PERIOD_DEF,
    parameter bit          IS_FADE = 1'b1
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [lbf_pkg::TIME_W-1:0]  time_ms,
    output logic [lbf_pkg::LEVEL_W-1:0] level
);
    import lbf_pkg::*;

    localparam int PW    = PERIOD_W;
    localparam int NUM_W = PW + Q_W;
    localparam logic [PW:0] P_EXT  = (PW + 1)'(PERIOD);
    localparam logic [PW:0] H_EXT  = (PW + 1)'(PERIOD / 2);

    logic [PW-1:0]     rem_reg [MOD_STAGES];
    logic [TIME_W-1:0] tsh_reg [MOD_STAGES-1];

    // restoring reduction, MOD_BITS time bits per stage
    for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
        logic [PW-1:0]     rem_in;
        logic [PW-1:0]     rem_out;
        logic [TIME_W-1:0] t_in;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign t_in   = time_ms;
        end
        else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign t_in   = tsh_reg[s-1];
        end

        always_comb
        begin
            logic [PW:0]       r;
            logic [TIME_W-1:0] t;
            r = {1'b0, rem_in};
            t = t_in;
            for (int j = 0; j < MOD_BITS; j++)
            begin
                r = {r[PW-1:0], t[TIME_W-1]};
                t = t << 1;
                if (r >= P_EXT)
                begin
                    r = r - P_EXT;
                end
            end
            rem_out = r[PW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_out;
            end
        end

        if (s < MOD_STAGES - 1) begin : g_tsh
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tsh_reg[s] <= t_in << MOD_BITS;
                end
            end
        end
    end

    logic [PW-1:0] t_mod;
    logic          below_half;

    assign t_mod      = rem_reg[MOD_STAGES-1];
    assign below_half = {1'b0, t_mod} < H_EXT;

    if (IS_FADE) begin : g_fade
        logic [NUM_W-1:0] num_reg;
        logic [NUM_W-1:0] drem_reg [DIV_STAGES-1];
        logic [Q_W-1:0]   dq_reg   [DIV_STAGES];
        logic [PW-1:0]    x;
        logic [PW:0]      falling;

        // rising or falling side, then 510 * x
        assign falling = P_EXT - {1'b0, t_mod};
        assign x       = below_half ? t_mod : falling[PW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg <= {x, 9'd0} - {{(Q_W - 1){1'b0}}, x, 1'b0};
            end
        end

        // long division by the period, DIV_BITS quotient bits per stage
        for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
            logic [NUM_W-1:0] r_in;
            logic [Q_W-1:0]   q_in;
            logic [NUM_W-1:0] r_out;
            logic [Q_W-1:0]   q_out;

            if (d == 0) begin : g_first
                assign r_in = num_reg;
                assign q_in = '0;
            end
            else begin : g_next
                assign r_in = drem_reg[d-1];
                assign q_in = dq_reg[d-1];
            end

            always_comb
            begin
                logic [NUM_W-1:0] r;
                logic [Q_W-1:0]   q;
                logic [NUM_W-1:0] dv;
                r = r_in;
                q = q_in;
                for (int k = 0; k < DIV_BITS; k++)
                begin
                    dv = NUM_W'(PERIOD) << (Q_W - 1 - d * DIV_BITS - k);
                    if (r >= dv)
                    begin
                        r = r - dv;
                        q = {q[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[Q_W-2:0], 1'b0};
                    end
                end
                r_out = r;
                q_out = q;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dq_reg[d] <= q_out;
                end
            end

            if (d < DIV_STAGES - 1) begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        drem_reg[d] <= r_out;
                    end
                end
            end
        end

        // odd periods can overshoot at the turn point
        assign level = (dq_reg[DIV_STAGES-1] > Q_W'(LEVEL_FULL))
                       ? LEVEL_FULL : dq_reg[DIV_STAGES-1][LEVEL_W-1:0];
    end
    else begin : g_blink
        logic [LEVEL_W-1:0] blink_reg [POST_STAGES];

        // delay to match the fade path
        for (genvar d = 0; d < POST_STAGES; d++) begin : g_dly
            if (d == 0) begin : g_head
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        blink_reg[d] <= below_half ? '0 : LEVEL_FULL;
                    end
                end
            end
            else begin : g_shift
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        blink_reg[d] <= blink_reg[d-1];
                    end
                end
            end
        end

        assign level = blink_reg[POST_STAGES-1];
    end

endmodule

FILE: rtl/core/lbf_led_lane.sv
`timescale 1ns / 1ps
// lbf_led_lane: mode and last-written state of one led, level pick and change check
// depends on lbf_pkg

module lbf_led_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  lbf_pkg::lane_cmd_t cmd,
    input  lbf_pkg::level_vec_t levels,
    output lbf_pkg::lane_res_t res
);
    import lbf_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [LEVEL_W:0]   prev_level_reg;
    logic               prev_lit_reg;
    logic [MODE_W-1:0]  eff_mode;
    logic [LEVEL_W-1:0] lvl;

    // an led switched off falls back to fixed
    assign eff_mode = cmd.lit ? mode_reg : MODE_FIXED;

    // pattern pick
    always_comb
    begin
        case (eff_mode)
            MODE_FAST_BLINK: lvl = levels[PAT_FAST_BLINK];
            MODE_BLINK:      lvl = levels[PAT_BLINK];
            MODE_FAST_FADE:  lvl = levels[PAT_FAST_FADE];
            MODE_FADE:       lvl = levels[PAT_FADE];
            default:         lvl = LEVEL_FULL;
        endcase
    end

    assign res.changed = ({1'b0, lvl} != prev_level_reg) || (cmd.lit != prev_lit_reg);
    assign res.level   = cmd.lit ? lvl : '0;

    // state commit when the transaction leaves the tail
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_FIXED;
            prev_level_reg <= LEVEL_NONE;
            prev_lit_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (cmd.is_set)
            begin
                if (cmd.set_hit)
                begin
                    mode_reg <= cmd.mode_code;
                end
            end
            else
            begin
                mode_reg <= eff_mode;
                if (res.changed)
                begin
                    prev_level_reg <= {1'b0, lvl};
                    prev_lit_reg   <= cmd.lit;
                end
            end
        end
    end

endmodule

FILE: rtl/core/led_blink_fade_pwm_driver.sv
`timescale 1ns / 1ps
// Three-led status driver: blink and triangle fade levels, pwm writes on change.
// Pipeline: 12 stages (8 for time mod period, 4 for the fade multiply and divide), then
// the merge stage, then the output register. Throughput: one transaction a cycle while
// the merge stage can take it; an update with several writes holds the merge stage until
// they drain, and pwm back-pressure stalls it. Reset clears modes to fixed, state at once.

module led_blink_fade_pwm_driver #(
    parameter int unsigned FAST_BLINK_PERIOD = lbf_pkg::FAST_BLINK_PERIOD_DEF,
    parameter int unsigned BLINK_PERIOD      = lbf_pkg::BLINK_PERIOD_DEF,
    parameter int unsigned FAST_FADE_PERIOD  = lbf_pkg::FAST_FADE_PERIOD_DEF,
    parameter int unsigned FADE_PERIOD       = lbf_pkg::FADE_PERIOD_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    lbf_stream_if.sink   cmd,
    lbf_stream_if.source pwm
);
    import lbf_pkg::*;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] led_select;
        logic [MODE_W-1:0]  mode_code;
        logic [NUM_LEDS-1:0] lit;
    } side_t;

    localparam int TAIL = PIPE_DEPTH - 1;

    in_item_t   item;
    logic       en;
    logic       vld_reg  [PIPE_DEPTH];
    side_t      side_reg [PIPE_DEPTH];
    level_vec_t levels;

    assign item      = cmd.payload;
    assign cmd.ready = en;

    // pattern levels, one unit per period
    lbf_period_unit #(.PERIOD(FAST_BLINK_PERIOD), .IS_FADE(1'b0)) u_fast_blink (
        .clk(clk), .en(en), .time_ms(item.time_ms), .level(levels[PAT_FAST_BLINK])
    );
    lbf_period_unit #(.PERIOD(BLINK_PERIOD), .IS_FADE(1'b0)) u_blink (
        .clk(clk), .en(en), .time_ms(item.time_ms), .level(levels[PAT_BLINK])
    );
    lbf_period_unit #(.PERIOD(FAST_FADE_PERIOD), .IS_FADE(1'b1)) u_fast_fade (
        .clk(clk), .en(en), .time_ms(item.time_ms), .level(levels[PAT_FAST_FADE])
    );
    lbf_period_unit #(.PERIOD(FADE_PERIOD), .IS_FADE(1'b1)) u_fade (
        .clk(clk), .en(en), .time_ms(item.time_ms), .level(levels[PAT_FADE])
    );

    // sideband and valid bits travel with the level pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE_DEPTH; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= cmd.valid;
            for (int s = 1; s < PIPE_DEPTH; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{action:     item.action,
                             led_select: item.led_select,
                             mode_code:  item.mode_code,
                             lit:        {item.wifi_en, item.battery_en, item.alarm_en}};
            for (int s = 1; s < PIPE_DEPTH; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // merge stage state
    logic [NUM_LEDS-1:0]              pend_mask_reg;
    logic [NUM_LEDS-1:0]              pend_mask_next;
    logic [NUM_LEDS-1:0][LEVEL_W-1:0] pend_lvl_reg;
    logic [NUM_LEDS-1:0]              rest;
    logic [INDEX_W-1:0]               pop_idx;
    logic                             pop;
    logic                             can_take;
    logic                             tail_take;
    logic                             out_valid_reg;
    out_item_t                        out_reg;
    lane_res_t [NUM_LEDS-1:0]         lane_res;
    logic [NUM_LEDS-1:0]              changed_vec;

    // one lane per led
    for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
        lane_cmd_t lane_cmd;

        assign lane_cmd.is_set    = side_reg[TAIL].action == ACT_SET_MODE;
        assign lane_cmd.set_hit   = side_reg[TAIL].led_select == INDEX_W'(i);
        assign lane_cmd.mode_code = side_reg[TAIL].mode_code;
        assign lane_cmd.lit       = side_reg[TAIL].lit[i];

        lbf_led_lane u_lane (
            .clk(clk), .rst_n(rst_n), .take(tail_take),
            .cmd(lane_cmd), .levels(levels), .res(lane_res[i])
        );

        assign changed_vec[i] = lane_res[i].changed;
    end

    // lowest pending led goes out first
    always_comb
    begin
        pop_idx = '0;
        for (int i = NUM_LEDS - 1; i >= 0; i--)
        begin
            if (pend_mask_reg[i])
            begin
                pop_idx = INDEX_W'(i);
            end
        end
    end

    assign rest      = pend_mask_reg & (pend_mask_reg - 1'b1);
    assign pop       = (pend_mask_reg != '0) && (!out_valid_reg || pwm.ready);
    assign can_take  = (pend_mask_reg == '0) || (pop && (rest == '0));
    assign tail_take = vld_reg[TAIL] && can_take;
    assign en        = !vld_reg[TAIL] || can_take;

    always_comb
    begin
        if (tail_take && (side_reg[TAIL].action == ACT_UPDATE))
        begin
            pend_mask_next = changed_vec;
        end
        else if (pop)
        begin
            pend_mask_next = rest;
        end
        else
        begin
            pend_mask_next = pend_mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_mask_reg <= pend_mask_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pwm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the merge and output registers
    always_ff @(posedge clk)
    begin
        if (tail_take)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                pend_lvl_reg[i] <= lane_res[i].level;
            end
        end
        if (pop)
        begin
            out_reg <= '{led_index: pop_idx,
                         pwm_level: pend_lvl_reg[pop_idx],
                         last:      rest == '0};
        end
    end

    assign pwm.valid   = out_valid_reg;
    assign pwm.payload = out_reg;

    // a write not marked last always has more writes queued behind it
    a_not_last_has_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last |-> pend_mask_reg != '0)
        else $error("write without last flag but nothing queued");

    // a set-mode transaction leaves nothing to write
    a_set_mode_silent: assert property (@(posedge clk) disable iff (!rst_n)
        tail_take && (side_reg[TAIL].action == ACT_SET_MODE) |=> pend_mask_reg == '0)
        else $error("set-mode transaction queued writes");

endmodule
